// ----- sv/alr_pkg.sv -----
// Shared types and constants of the anti-aliased line rasterizer.
package alr_pkg;

    // Fixed field widths
    localparam int SCREEN_BITS    = 13;
    localparam int BPP_BITS       = 3;
    localparam int OFFSET_BITS    = 26;
    localparam int LEVEL_BITS     = 8;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 13;

    // Register reset values
    localparam logic [SCREEN_BITS-1:0] WIDTH_RESET  = 13'd1024;
    localparam logic [SCREEN_BITS-1:0] HEIGHT_RESET = 13'd768;
    localparam logic [BPP_BITS-1:0]    BPP_RESET    = 3'd3;

    // Register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SCREEN_WIDTH    = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SCREEN_HEIGHT   = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_BYTES_PER_PIXEL = 2'd2;

    // Input item kinds
    localparam logic KIND_START = 1'b0;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_NEAR_MUL,
        S_NEAR_OUT,
        S_FAR_MUL,
        S_FAR_OUT,
        S_ADV
    } alr_state_t;

    // Controller to datapath
    typedef struct packed {
        logic start_load;
        logic div_start;
        logic lin_load;
        logic out_load;
        logic sel_far;
        logic advance;
    } alr_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic start_flat;
        logic busy;
        logic div_done;
        logic near_ok;
        logic far_ok;
        logic out_free;
    } alr_sts_t;

endpackage

// ----- sv/antialiased_line_raster_top.sv -----
// Top level of the anti-aliased line rasterizer.
// Takes one item at a time. A start item whose endpoints coincide needs no slope;
// any other start runs the bit-serial slope divider, one quotient bit per cycle, and
// the input stays stalled until the divider is done.
// A step while no line is running is taken and leaves the block idle. A running step
// visits the near and then the far pixel, each visible one getting its row multiply
// and then the bytes-per-pixel multiply into the output register, before the step
// advances; a stalled output register holds the step. The output register lets the
// next item enter while the last pixel of a step still waits for its transfer.
// Configuration writes are always taken and must only be issued while idle.
module antialiased_line_raster_top #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                kind,
    input  logic [COORD_BITS-1:0]               start_x,
    input  logic [COORD_BITS-1:0]               start_y,
    input  logic [COORD_BITS-1:0]               end_x,
    input  logic [COORD_BITS-1:0]               end_y,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [COORD_BITS-1:0]               pix_x,
    output logic [COORD_BITS-1:0]               pix_y,
    output logic [alr_pkg::OFFSET_BITS-1:0]     byte_offset,
    output logic [alr_pkg::LEVEL_BITS-1:0]      level,
    output logic                                last,
    output logic                                line_done,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [alr_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [alr_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

    alr_pkg::alr_cmd_t cmd;
    alr_pkg::alr_sts_t sts;

    assign cfg_ready = 1'b1;

    alr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .kind     (kind),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    alr_dp #(
        .C (COORD_BITS),
        .F (FRAC_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .cfg_we      (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .start_x     (start_x),
        .start_y     (start_y),
        .end_x       (end_x),
        .end_y       (end_y),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .pix_x       (pix_x),
        .pix_y       (pix_y),
        .byte_offset (byte_offset),
        .level       (level),
        .last        (last),
        .line_done   (line_done)
    );

endmodule

// ----- sv/alr_div.sv -----
// Bit-serial restoring divider for the slope: (num << F) / den.
module alr_div #(
    parameter int C = 12,
    parameter int F = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [C-1:0] num,
    input  logic [C-1:0] den,
    output logic         done,
    output logic [F:0]   quot
);

    localparam int N  = C + F;
    localparam int CW = $clog2(N + 1);

    logic [N-1:0]  dvd_reg;
    logic [C-1:0]  rem_reg;
    logic [C-1:0]  den_reg;
    logic [F:0]    quot_reg;
    logic [CW-1:0] cnt_reg;
    logic          run_reg;
    logic          done_reg;

    logic [C:0]    rem_sh;
    logic [C:0]    rem_sub;
    logic          fits;
    logic          done_next;

    // One quotient bit per cycle
    always_comb
    begin
        rem_sh    = {rem_reg, dvd_reg[N-1]};
        rem_sub   = rem_sh - {1'b0, den_reg};
        fits      = rem_sh >= {1'b0, den_reg};
        done_next = run_reg && (cnt_reg == CW'(1));
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= done_next;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CW'(N);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - CW'(1);
                if (done_next)
                begin
                    run_reg <= 1'b0;
                end
            end
        end
    end

    // Operands and partial results
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg  <= {num, {F{1'b0}}};
            den_reg  <= den;
            rem_reg  <= '0;
            quot_reg <= '0;
        end
        else if (run_reg)
        begin
            dvd_reg  <= {dvd_reg[N-2:0], 1'b0};
            rem_reg  <= fits ? rem_sub[C-1:0] : rem_sh[C-1:0];
            quot_reg <= {quot_reg[F-1:0], fits};
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

// ----- sv/alr_dp.sv -----
// Datapath: line setup, accumulator, pixel address and level, output register.
module alr_dp #(
    parameter int C = 12,
    parameter int F = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  alr_pkg::alr_cmd_t                   cmd,
    output alr_pkg::alr_sts_t                   sts,
    input  logic                                cfg_we,
    input  logic [alr_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [alr_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  logic [C-1:0]                        start_x,
    input  logic [C-1:0]                        start_y,
    input  logic [C-1:0]                        end_x,
    input  logic [C-1:0]                        end_y,
    input  logic                                out_stall,
    output logic                                out_valid,
    output logic [C-1:0]                        pix_x,
    output logic [C-1:0]                        pix_y,
    output logic [alr_pkg::OFFSET_BITS-1:0]     byte_offset,
    output logic [alr_pkg::LEVEL_BITS-1:0]      level,
    output logic                                last,
    output logic                                line_done
);

    localparam int AW  = C + F;
    localparam int SW  = F + 2;
    localparam int VW  = (C + 1 > alr_pkg::SCREEN_BITS) ? C + 1 : alr_pkg::SCREEN_BITS;
    localparam int PW  = alr_pkg::SCREEN_BITS + C + 1;
    localparam int LW  = (PW > alr_pkg::OFFSET_BITS) ? PW : alr_pkg::OFFSET_BITS;
    localparam int OW  = alr_pkg::OFFSET_BITS;
    localparam int LVW = alr_pkg::LEVEL_BITS;

    // Configuration registers
    logic [alr_pkg::SCREEN_BITS-1:0] width_reg;
    logic [alr_pkg::SCREEN_BITS-1:0] height_reg;
    logic [alr_pkg::BPP_BITS-1:0]    bpp_reg;

    // Line state
    logic          busy_reg;
    logic          steep_reg;
    logic          down_reg;
    logic          neg_reg;
    logic [C-1:0]  pos_reg;
    logic [C-1:0]  end_reg;
    logic [AW-1:0] acc_reg;
    logic [SW-1:0] slope_reg;
    logic [OW-1:0] lin_reg;

    // Output register
    logic          out_valid_reg;
    logic [C-1:0]  pix_x_reg;
    logic [C-1:0]  pix_y_reg;
    logic [OW-1:0] offset_reg;
    logic [LVW-1:0] level_reg;
    logic          last_reg;
    logic          done_reg;

    // Setup signals
    logic          swap;
    logic [C-1:0]  x1;
    logic [C-1:0]  y1;
    logic [C-1:0]  x2;
    logic [C-1:0]  y2;
    logic [C-1:0]  dx;
    logic [C-1:0]  ady;
    logic          y_up;
    logic          steep;
    logic [C-1:0]  major_delta;
    logic [C-1:0]  minor_delta;

    logic          div_done;
    logic [F:0]    quot;

    // Step signals
    logic [C-1:0]  minor;
    logic [C:0]    minor_p1;
    logic [F-1:0]  frac;
    logic [F:0]    near_w;
    logic [F+8:0]  near_prod;
    logic [F+7:0]  far_prod;
    logic [LVW-1:0] lv_near;
    logic [LVW-1:0] lv_far;
    logic [C-1:0]  near_x;
    logic [C-1:0]  near_y;
    logic [C-1:0]  far_x;
    logic [C-1:0]  far_y;
    logic [VW-1:0] near_xw;
    logic [VW-1:0] near_yw;
    logic [VW-1:0] far_xw;
    logic [VW-1:0] far_yw;
    logic          near_ok;
    logic          far_ok;
    logic [C-1:0]  sel_x;
    logic [C-1:0]  sel_y;
    logic [LW-1:0] lin_next;
    logic [C-1:0]  pos_next;
    logic          pos_done;
    logic          out_free;

    // Endpoint ordering and axis choice
    always_comb
    begin
        swap        = end_x < start_x;
        x1          = swap ? end_x : start_x;
        y1          = swap ? end_y : start_y;
        x2          = swap ? start_x : end_x;
        y2          = swap ? start_y : end_y;
        dx          = x2 - x1;
        y_up        = y2 >= y1;
        ady         = y_up ? (y2 - y1) : (y1 - y2);
        steep       = ady > dx;
        major_delta = steep ? ady : dx;
        minor_delta = steep ? dx : ady;
    end

    alr_div #(
        .C (C),
        .F (F)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (minor_delta),
        .den   (major_delta),
        .done  (div_done),
        .quot  (quot)
    );

    // Pixel candidates and levels for the current position
    always_comb
    begin
        minor     = acc_reg[AW-1:F];
        frac      = acc_reg[F-1:0];
        minor_p1  = {1'b0, minor} + (C+1)'(1);
        near_w    = {1'b1, {F{1'b0}}} - {1'b0, frac};
        near_prod = {near_w, 8'b0} - {8'b0, near_w};
        far_prod  = {frac, 8'b0} - {8'b0, frac};
        lv_near   = near_prod[F+7:F];
        lv_far    = far_prod[F+7:F];

        near_x  = steep_reg ? minor : pos_reg;
        near_y  = steep_reg ? pos_reg : minor;
        far_x   = steep_reg ? minor_p1[C-1:0] : pos_reg;
        far_y   = steep_reg ? pos_reg : minor_p1[C-1:0];
        near_xw = VW'(near_x);
        near_yw = VW'(near_y);
        far_xw  = steep_reg ? VW'(minor_p1) : VW'(pos_reg);
        far_yw  = steep_reg ? VW'(pos_reg) : VW'(minor_p1);

        near_ok = (near_xw < VW'(width_reg)) && (near_yw < VW'(height_reg));
        far_ok  = !minor_p1[C] && (far_xw < VW'(width_reg))
                  && (far_yw < VW'(height_reg));

        sel_x    = cmd.sel_far ? far_x : near_x;
        sel_y    = cmd.sel_far ? far_y : near_y;
        lin_next = LW'(width_reg) * LW'(sel_y) + LW'(sel_x);

        pos_next = down_reg ? (pos_reg - C'(1)) : (pos_reg + C'(1));
        pos_done = pos_next == end_reg;
        out_free = !out_valid_reg || !out_stall;
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= alr_pkg::WIDTH_RESET;
            height_reg <= alr_pkg::HEIGHT_RESET;
            bpp_reg    <= alr_pkg::BPP_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                alr_pkg::CFG_SCREEN_WIDTH:    width_reg  <= cfg_data;
                alr_pkg::CFG_SCREEN_HEIGHT:   height_reg <= cfg_data;
                alr_pkg::CFG_BYTES_PER_PIXEL: bpp_reg    <= cfg_data[alr_pkg::BPP_BITS-1:0];
                default:                      ;
            endcase
        end
    end

    // Line state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            steep_reg <= 1'b0;
            down_reg  <= 1'b0;
            neg_reg   <= 1'b0;
            pos_reg   <= '0;
            end_reg   <= '0;
            acc_reg   <= '0;
            slope_reg <= '0;
        end
        else if (cmd.start_load)
        begin
            busy_reg  <= 1'b0;
            steep_reg <= steep;
            down_reg  <= steep && !y_up;
            neg_reg   <= !steep && !y_up;
            pos_reg   <= steep ? y1 : x1;
            end_reg   <= steep ? y2 : x2;
            acc_reg   <= {(steep ? x1 : y1), {F{1'b0}}};
        end
        else if (div_done)
        begin
            busy_reg  <= 1'b1;
            slope_reg <= neg_reg ? (SW'(0) - {1'b0, quot}) : {1'b0, quot};
        end
        else if (cmd.advance)
        begin
            acc_reg <= acc_reg + {{(AW-SW){slope_reg[SW-1]}}, slope_reg};
            pos_reg <= pos_next;
            if (pos_done)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Row-major linear index of the selected pixel
    always_ff @(posedge clk)
    begin
        if (cmd.lin_load)
        begin
            lin_reg <= lin_next[OW-1:0];
        end
    end

    // Output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            pix_x_reg  <= sel_x;
            pix_y_reg  <= sel_y;
            offset_reg <= OW'(bpp_reg) * lin_reg;
            level_reg  <= cmd.sel_far ? lv_far : lv_near;
            last_reg   <= cmd.sel_far || !far_ok;
            done_reg   <= pos_done;
        end
    end

    always_comb
    begin
        sts.start_flat = major_delta == C'(0);
        sts.busy       = busy_reg;
        sts.div_done   = div_done;
        sts.near_ok    = near_ok;
        sts.far_ok     = far_ok;
        sts.out_free   = out_free;
    end

    assign out_valid   = out_valid_reg;
    assign pix_x       = pix_x_reg;
    assign pix_y       = pix_y_reg;
    assign byte_offset = offset_reg;
    assign level       = level_reg;
    assign last        = last_reg;
    assign line_done   = done_reg;

endmodule

// ----- sv/alr_ctrl.sv -----
// Controller state machine: sequences line setup and the up to two pixel writes of a step.
module alr_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              kind,
    output logic              in_stall,
    input  alr_pkg::alr_sts_t sts,
    output alr_pkg::alr_cmd_t cmd
);

    alr_pkg::alr_state_t state_reg;
    alr_pkg::alr_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= alr_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            alr_pkg::S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    if (kind == alr_pkg::KIND_START)
                    begin
                        cmd.start_load = 1'b1;
                        if (!sts.start_flat)
                        begin
                            cmd.div_start = 1'b1;
                            state_next    = alr_pkg::S_DIV;
                        end
                    end
                    else if (sts.busy)
                    begin
                        state_next = alr_pkg::S_NEAR_MUL;
                    end
                end
            end
            alr_pkg::S_DIV:
            begin
                if (sts.div_done)
                begin
                    state_next = alr_pkg::S_IDLE;
                end
            end
            alr_pkg::S_NEAR_MUL:
            begin
                if (sts.near_ok)
                begin
                    cmd.lin_load = 1'b1;
                    state_next   = alr_pkg::S_NEAR_OUT;
                end
                else
                begin
                    state_next = alr_pkg::S_FAR_MUL;
                end
            end
            alr_pkg::S_NEAR_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = alr_pkg::S_FAR_MUL;
                end
            end
            alr_pkg::S_FAR_MUL:
            begin
                cmd.sel_far = 1'b1;
                if (sts.far_ok)
                begin
                    cmd.lin_load = 1'b1;
                    state_next   = alr_pkg::S_FAR_OUT;
                end
                else
                begin
                    state_next = alr_pkg::S_ADV;
                end
            end
            alr_pkg::S_FAR_OUT:
            begin
                cmd.sel_far = 1'b1;
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = alr_pkg::S_ADV;
                end
            end
            alr_pkg::S_ADV:
            begin
                cmd.advance = 1'b1;
                state_next  = alr_pkg::S_IDLE;
            end
            default:
            begin
                state_next = alr_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ----- sv/alr_checker.sv -----
// Port-level checks of the line rasterizer and their binding to the top level.
module alr_checker #(
    parameter int COORD_BITS = 12
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_stall,
    input  logic                            kind,
    input  logic [COORD_BITS-1:0]           start_x,
    input  logic [COORD_BITS-1:0]           start_y,
    input  logic [COORD_BITS-1:0]           end_x,
    input  logic [COORD_BITS-1:0]           end_y,
    input  logic                            out_valid,
    input  logic                            out_stall,
    input  logic [COORD_BITS-1:0]           pix_x,
    input  logic [COORD_BITS-1:0]           pix_y,
    input  logic [alr_pkg::OFFSET_BITS-1:0] byte_offset,
    input  logic [alr_pkg::LEVEL_BITS-1:0]  level,
    input  logic                            last,
    input  logic                            line_done
);

    // A stalled result holds until its transfer
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(pix_x) && $stable(pix_y)
            && $stable(byte_offset) && $stable(level) && $stable(last)
            && $stable(line_done))
        else $error("stalled pixel write changed");

    // A point line needs no slope and leaves the block ready
    a_flat_start: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (kind == alr_pkg::KIND_START)
            && (start_x == end_x) && (start_y == end_y) |=> !in_stall)
        else $error("point line did not stay idle");

    // Any other start runs the slope divider and stalls input
    a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (kind == alr_pkg::KIND_START)
            && ((start_x != end_x) || (start_y != end_y)) |=> in_stall)
        else $error("line start did not run the slope divider");

    // The divider does not end the input stall straight after it starts
    a_div_length: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (kind == alr_pkg::KIND_START)
            && ((start_x != end_x) || (start_y != end_y)) |=> ##1 in_stall)
        else $error("slope divider finished too early");

endmodule

bind antialiased_line_raster_top alr_checker #(
    .COORD_BITS (COORD_BITS)
) u_alr_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .kind        (kind),
    .start_x     (start_x),
    .start_y     (start_y),
    .end_x       (end_x),
    .end_y       (end_y),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pix_x       (pix_x),
    .pix_y       (pix_y),
    .byte_offset (byte_offset),
    .level       (level),
    .last        (last),
    .line_done   (line_done)
);

// ----- tb/alr_pixel_checker.sv -----
// Checker for the anti-aliased line rasterizer: line walk predictor and pixel write compare.
`timescale 1ns / 1ps
module alr_pixel_checker #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_stall,
    input  logic                                kind,
    input  logic [COORD_BITS-1:0]               start_x,
    input  logic [COORD_BITS-1:0]               start_y,
    input  logic [COORD_BITS-1:0]               end_x,
    input  logic [COORD_BITS-1:0]               end_y,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic [COORD_BITS-1:0]               pix_x,
    input  logic [COORD_BITS-1:0]               pix_y,
    input  logic [alr_pkg::OFFSET_BITS-1:0]     byte_offset,
    input  logic [alr_pkg::LEVEL_BITS-1:0]      level,
    input  logic                                last,
    input  logic                                line_done,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [alr_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [alr_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    output int                                  mismatches,
    output int                                  pending
);

    localparam int ACC_BITS    = COORD_BITS + FRAC_BITS;
    localparam int SLOPE_BITS  = FRAC_BITS + 2;
    localparam int OFF_BITS    = alr_pkg::OFFSET_BITS;
    localparam int LVL_BITS    = alr_pkg::LEVEL_BITS;
    localparam int BPP_W       = alr_pkg::BPP_BITS;
    localparam int LEVEL_SCALE = 255;
    localparam int MAX_REPORTS = 10;

    typedef struct {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [OFF_BITS-1:0]   offset;
        logic [LVL_BITS-1:0]   level;
        logic                  last;
        logic                  done;
    } pixel_t;

    // Shadow copies of the configuration registers
    logic [alr_pkg::SCREEN_BITS-1:0] width_reg;
    logic [alr_pkg::SCREEN_BITS-1:0] height_reg;
    logic [BPP_W-1:0]                bpp_reg;

    // Line walk state
    logic                  line_busy;
    logic                  steep;
    logic                  major_down;
    logic [COORD_BITS-1:0] major_pos;
    logic [COORD_BITS-1:0] major_end;
    logic [ACC_BITS-1:0]   minor_acc;
    logic [SLOPE_BITS-1:0] slope;

    pixel_t expected_pixels[$];
    pixel_t step_pixels[$];
    pixel_t oldest;
    pixel_t seen;
    int     errors = 0;

    // Clip one pixel write against the coordinate range and the screen
    function automatic void add_pixel(longint x, longint y, longint lv);
        pixel_t p;
        if (x >= (longint'(1) << COORD_BITS) || y >= (longint'(1) << COORD_BITS))
            return;
        if (x >= longint'(width_reg) || y >= longint'(height_reg))
            return;
        p.x      = COORD_BITS'(x);
        p.y      = COORD_BITS'(y);
        p.offset = OFF_BITS'(longint'(bpp_reg) * (longint'(width_reg) * y + x));
        p.level  = LVL_BITS'(lv);
        p.last   = 1'b0;
        p.done   = 1'b0;
        step_pixels.push_back(p);
    endfunction

    // Start transfer: order endpoints, pick the major axis, form the slope
    function automatic void load_line(logic [COORD_BITS-1:0] ax, logic [COORD_BITS-1:0] ay,
                                      logic [COORD_BITS-1:0] bx, logic [COORD_BITS-1:0] by);
        logic [COORD_BITS-1:0] x1;
        logic [COORD_BITS-1:0] y1;
        logic [COORD_BITS-1:0] x2;
        logic [COORD_BITS-1:0] y2;
        longint dx;
        longint ady;
        longint major_delta;
        longint minor_delta;
        longint mag;
        logic   y_up;
        x1 = ax;
        y1 = ay;
        x2 = bx;
        y2 = by;
        if (bx < ax)
        begin
            x1 = bx;
            y1 = by;
            x2 = ax;
            y2 = ay;
        end
        dx   = longint'(x2) - longint'(x1);
        y_up = (y2 >= y1);
        ady  = y_up ? longint'(y2) - longint'(y1) : longint'(y1) - longint'(y2);
        steep = (ady > dx);
        if (steep)
        begin
            major_pos   = y1;
            major_end   = y2;
            major_down  = !y_up;
            minor_acc   = ACC_BITS'(longint'(x1) << FRAC_BITS);
            major_delta = ady;
            minor_delta = dx;
        end
        else
        begin
            major_pos   = x1;
            major_end   = x2;
            major_down  = 1'b0;
            minor_acc   = ACC_BITS'(longint'(y1) << FRAC_BITS);
            major_delta = dx;
            minor_delta = ady;
        end
        line_busy = (major_pos != major_end);
        mag = (major_delta != 0) ? (minor_delta << FRAC_BITS) / major_delta : 0;
        slope = (!steep && !y_up) ? SLOPE_BITS'(-mag) : SLOPE_BITS'(mag);
    endfunction

    // Step transfer: emit near and far pixels, then advance one major position
    function automatic void walk_position();
        longint              minor;
        longint              frac;
        longint              lv_near;
        longint              lv_far;
        logic [ACC_BITS-1:0] step_ext;
        logic                done;
        if (!line_busy)
            return;
        step_pixels.delete();
        minor   = longint'(minor_acc >> FRAC_BITS);
        frac    = longint'(minor_acc) & ((longint'(1) << FRAC_BITS) - 1);
        lv_near = (((longint'(1) << FRAC_BITS) - frac) * LEVEL_SCALE) >> FRAC_BITS;
        lv_far  = (frac * LEVEL_SCALE) >> FRAC_BITS;
        if (steep)
        begin
            add_pixel(minor, longint'(major_pos), lv_near);
            add_pixel(minor + 1, longint'(major_pos), lv_far);
        end
        else
        begin
            add_pixel(longint'(major_pos), minor, lv_near);
            add_pixel(longint'(major_pos), minor + 1, lv_far);
        end
        step_ext  = ACC_BITS'($signed(slope));
        minor_acc = minor_acc + step_ext;
        major_pos = major_down ? major_pos - 1'b1 : major_pos + 1'b1;
        done      = (major_pos == major_end);
        if (done)
            line_busy = 1'b0;
        foreach (step_pixels[i])
        begin
            step_pixels[i].done = done;
            step_pixels[i].last = (i == step_pixels.size() - 1);
            expected_pixels.push_back(step_pixels[i]);
        end
    endfunction

    // Track register writes, predict on input transfers, compare output transfers
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  = alr_pkg::WIDTH_RESET;
            height_reg = alr_pkg::HEIGHT_RESET;
            bpp_reg    = alr_pkg::BPP_RESET;
            line_busy  = 1'b0;
            steep      = 1'b0;
            major_down = 1'b0;
            major_pos  = '0;
            major_end  = '0;
            minor_acc  = '0;
            slope      = '0;
            expected_pixels.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    alr_pkg::CFG_SCREEN_WIDTH:    width_reg  = cfg_data;
                    alr_pkg::CFG_SCREEN_HEIGHT:   height_reg = cfg_data;
                    alr_pkg::CFG_BYTES_PER_PIXEL: bpp_reg    = cfg_data[BPP_W-1:0];
                    default: ;
                endcase
            end

            if (in_valid && !in_stall)
            begin
                if (kind == alr_pkg::KIND_START)
                    load_line(start_x, start_y, end_x, end_y);
                else
                    walk_position();
            end

            if (out_valid && !out_stall)
            begin
                seen.x      = pix_x;
                seen.y      = pix_y;
                seen.offset = byte_offset;
                seen.level  = level;
                seen.last   = last;
                seen.done   = line_done;
                if (expected_pixels.size() == 0)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                    begin
                        $display("%0t: unexpected pixel write", $realtime);
                        $display("  actual   x=%0d y=%0d off=%0d lvl=%0d last=%0b done=%0b",
                                 seen.x, seen.y, seen.offset, seen.level,
                                 seen.last, seen.done);
                    end
                end
                else
                begin
                    oldest = expected_pixels.pop_front();
                    if (seen.x !== oldest.x || seen.y !== oldest.y ||
                        seen.offset !== oldest.offset || seen.level !== oldest.level ||
                        seen.last !== oldest.last || seen.done !== oldest.done)
                    begin
                        errors++;
                        if (errors <= MAX_REPORTS)
                        begin
                            $display("%0t: pixel write mismatch", $realtime);
                            $display("  expected x=%0d y=%0d off=%0d lvl=%0d",
                                     oldest.x, oldest.y, oldest.offset, oldest.level,
                                     " last=%0b done=%0b", oldest.last, oldest.done);
                            $display("  actual   x=%0d y=%0d off=%0d lvl=%0d",
                                     seen.x, seen.y, seen.offset, seen.level,
                                     " last=%0b done=%0b", seen.last, seen.done);
                        end
                    end
                end
            end
        end
        mismatches <= errors;
        pending    <= expected_pixels.size();
    end

endmodule

// ----- tb/antialiased_line_raster_top_tb.sv -----
// Stimulus and verdict for the anti-aliased line rasterizer, checked by alr_pixel_checker.
`timescale 1ns / 1ps
module antialiased_line_raster_top_tb;

    localparam int   COORD_BITS     = 12;
    localparam int   FRAC_BITS      = 16;
    localparam int   COORD_MAX      = (1 << COORD_BITS) - 1;
    localparam int   RESET_CYCLES   = 12;
    localparam int   SETTLE_CYCLES  = 64;
    localparam int   WATCHDOG_LIMIT = 2000;
    localparam int   NUM_PHASES     = 6;
    localparam int   PHASE_ITEMS    = 235;
    localparam logic KIND_STEP      = ~alr_pkg::KIND_START;

    // Receiver stall patterns
    localparam int STALL_NONE     = 0;
    localparam int STALL_LIGHT    = 1;
    localparam int STALL_HEAVY    = 2;
    localparam int STALL_PERIODIC = 3;

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                in_valid = 1'b0;
    logic                                in_stall;
    logic                                kind = alr_pkg::KIND_START;
    logic [COORD_BITS-1:0]               start_x = '0;
    logic [COORD_BITS-1:0]               start_y = '0;
    logic [COORD_BITS-1:0]               end_x = '0;
    logic [COORD_BITS-1:0]               end_y = '0;
    logic                                out_valid;
    logic                                out_stall = 1'b0;
    logic [COORD_BITS-1:0]               pix_x;
    logic [COORD_BITS-1:0]               pix_y;
    logic [alr_pkg::OFFSET_BITS-1:0]     byte_offset;
    logic [alr_pkg::LEVEL_BITS-1:0]      level;
    logic                                last;
    logic                                line_done;
    logic                                cfg_valid = 1'b0;
    logic                                cfg_ready;
    logic [alr_pkg::CFG_INDEX_BITS-1:0]  cfg_index = alr_pkg::CFG_SCREEN_WIDTH;
    logic [alr_pkg::CFG_DATA_BITS-1:0]   cfg_data = '0;

    int mismatches;
    int pending;
    int burst_left = 0;
    int phase_items = 0;
    int quiet_cycles = 0;
    int stall_mode = STALL_NONE;
    int stall_left = 0;

    always #5 clk = ~clk;

    antialiased_line_raster_top #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .kind        (kind),
        .start_x     (start_x),
        .start_y     (start_y),
        .end_x       (end_x),
        .end_y       (end_y),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .pix_x       (pix_x),
        .pix_y       (pix_y),
        .byte_offset (byte_offset),
        .level       (level),
        .last        (last),
        .line_done   (line_done),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    alr_pixel_checker #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .kind        (kind),
        .start_x     (start_x),
        .start_y     (start_y),
        .end_x       (end_x),
        .end_y       (end_y),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .pix_x       (pix_x),
        .pix_y       (pix_y),
        .byte_offset (byte_offset),
        .level       (level),
        .last        (last),
        .line_done   (line_done),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .pending     (pending)
    );

    // Receiver stall: switches between patterns, including stretches with no stall
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(STALL_NONE, STALL_PERIODIC);
            stall_left = $urandom_range(20, 200);
        end
        else
            stall_left--;
        case (stall_mode)
            STALL_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY:    out_stall <= ($urandom_range(0, 1) == 1);
            STALL_PERIODIC: out_stall <= ((stall_left % 16) < 6);
            default:        out_stall <= 1'b0;
        endcase
    end

    // Watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL antialiased_line_raster_top");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic logic [COORD_BITS-1:0] clamp_coord(int v);
        if (v < 0)
            return '0;
        if (v > COORD_MAX)
            return COORD_BITS'(COORD_MAX);
        return COORD_BITS'(v);
    endfunction

    // One input transfer; bursts of random length with random gaps between them
    task automatic send_item(logic k, logic [COORD_BITS-1:0] sx, logic [COORD_BITS-1:0] sy,
                             logic [COORD_BITS-1:0] ex, logic [COORD_BITS-1:0] ey);
        int gap;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 120)
                                                      : $urandom_range(1, 8);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        kind     <= k;
        start_x  <= sx;
        start_y  <= sy;
        end_x    <= ex;
        end_y    <= ey;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Step with random don't-care endpoint fields
    task automatic send_step();
        send_item(KIND_STEP, COORD_BITS'($urandom), COORD_BITS'($urandom),
                  COORD_BITS'($urandom), COORD_BITS'($urandom));
    endtask

    // Hold off the sender until every expected pixel write has arrived
    task automatic drain();
        in_valid   <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_beat(logic [alr_pkg::CFG_INDEX_BITS-1:0] idx,
                            logic [alr_pkg::CFG_DATA_BITS-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic write_config(int w, int h, int b);
        cfg_beat(alr_pkg::CFG_SCREEN_WIDTH, alr_pkg::CFG_DATA_BITS'(w));
        cfg_beat(alr_pkg::CFG_SCREEN_HEIGHT, alr_pkg::CFG_DATA_BITS'(h));
        cfg_beat(alr_pkg::CFG_BYTES_PER_PIXEL, alr_pkg::CFG_DATA_BITS'(b));
        cfg_valid <= 1'b0;
    endtask

    // A start followed by its steps; sometimes preceded by a stray step, cut short or padded with an extra step
    task automatic random_line(int w, int h);
        int lim_w;
        int lim_h;
        int pick;
        int len;
        int adx;
        int ady;
        int steps;
        int n_send;
        logic [COORD_BITS-1:0] x1;
        logic [COORD_BITS-1:0] y1;
        logic [COORD_BITS-1:0] x2;
        logic [COORD_BITS-1:0] y2;
        lim_w = (w + 3 > COORD_MAX) ? COORD_MAX : w + 3;
        lim_h = (h + 3 > COORD_MAX) ? COORD_MAX : h + 3;
        pick  = $urandom_range(0, 99);
        if (pick < 70)
        begin
            x1 = COORD_BITS'($urandom_range(0, lim_w));
            y1 = COORD_BITS'($urandom_range(0, lim_h));
        end
        else if (pick < 90)
        begin
            x1 = COORD_BITS'($urandom);
            y1 = COORD_BITS'($urandom);
        end
        else
        begin
            x1 = $urandom_range(0, 1) ? COORD_BITS'(COORD_MAX) : '0;
            y1 = $urandom_range(0, 1) ? COORD_BITS'(COORD_MAX) : '0;
        end
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(0, 12);
        x2 = clamp_coord(int'(x1) + ($urandom_range(0, 1) ? 1 : -1) * $urandom_range(0, len));
        y2 = clamp_coord(int'(y1) + ($urandom_range(0, 1) ? 1 : -1) * $urandom_range(0, len));
        if ($urandom_range(0, 29) == 0)
        begin
            x2 = x1;
            y2 = y1;
        end
        adx   = (x2 > x1) ? int'(x2) - int'(x1) : int'(x1) - int'(x2);
        ady   = (y2 > y1) ? int'(y2) - int'(y1) : int'(y1) - int'(y2);
        steps = (ady > adx) ? ady : adx;

        // stray step ahead of the start
        if ($urandom_range(0, 24) == 0)
            send_step();
        send_item(alr_pkg::KIND_START, x1, y1, x2, y2);
        phase_items++;
        n_send = ($urandom_range(0, 9) == 0 && steps > 0) ? $urandom_range(0, steps - 1) : steps;
        repeat (n_send)
        begin
            send_step();
            phase_items++;
        end
        if (n_send == steps && $urandom_range(0, 11) == 0)
            send_step();
    endtask

    initial
    begin
        int phase_w[NUM_PHASES];
        int phase_h[NUM_PHASES];
        int phase_b[NUM_PHASES];

        phase_w = '{1, 4096, $urandom_range(8, 200), 1024, 4096, $urandom_range(100, 600)};
        phase_h = '{4096, 1, $urandom_range(8, 200), 768, 4096, $urandom_range(1, 64)};
        phase_b = '{1, 2, $urandom_range(1, 4), 3, 4, $urandom_range(1, 4)};

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed lines under the reset configuration
        send_step();                                        // step with no line running
        send_item(alr_pkg::KIND_START, 12'd5, 12'd5, 12'd5, 12'd5);   // coincident endpoints
        send_step();
        send_item(alr_pkg::KIND_START, 12'd0, 12'd0, 12'd2, 12'd1);   // zero frac, level 0 write
        repeat (2) send_step();
        send_item(alr_pkg::KIND_START, 12'd10, 12'd10, 12'd7, 12'd12); // swapped, y falling
        repeat (3) send_step();
        send_item(alr_pkg::KIND_START, 12'd20, 12'd30, 12'd21, 12'd27); // steep, counting down
        repeat (3) send_step();
        send_item(alr_pkg::KIND_START, 12'd0, 12'd0, 12'd5, 12'd5);   // diagonal, then abandoned
        send_step();
        send_item(alr_pkg::KIND_START, 12'd4095, 12'd0, 12'd4093, 12'd2); // fully off screen
        repeat (2) send_step();
        drain();

        // Largest screen: minor + 1 runs past the coordinate range on the bottom row
        write_config(4096, 4096, 4);
        send_item(alr_pkg::KIND_START, 12'd4091, 12'd4095, 12'd4095, 12'd4094);
        repeat (4) send_step();
        drain();

        // Random lines over several screen settings
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_config(phase_w[p], phase_h[p], phase_b[p]);
            phase_items = 0;
            while (phase_items < PHASE_ITEMS)
                random_line(phase_w[p], phase_h[p]);
            drain();
        end

        if (mismatches == 0 && pending == 0)
            $display("PASS antialiased_line_raster_top");
        else
            $display("FAIL antialiased_line_raster_top");
        $finish;
    end

endmodule
